// File: rtl/cblru_pkg.sv
// Shared types, codes and constants of the cost-bounded LRU cache.
`timescale 1ns / 1ps
package cblru_pkg;

    localparam int CBL_ENTRIES = 32;
    localparam logic [31:0] CBL_BUDGET_RESET = 32'(128 * 1024 * 1024);
    localparam logic [4:0] CBL_MAX_EVICT = 5'd31;
    localparam logic [63:0] CBL_TOTAL_MAX = 64'h0000_003F_FFFF_FFFF;

    localparam logic [2:0] REQ_LOOKUP = 3'd0;
    localparam logic [2:0] REQ_TOUCH  = 3'd1;
    localparam logic [2:0] REQ_STORE  = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_EVICT  = 3'd1;
    localparam logic [2:0] KIND_STORE  = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_CMP    = 3'd1;
    localparam logic [2:0] OP_TOUCH  = 3'd2;
    localparam logic [2:0] OP_DROP   = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_KILL   = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [3:0]  floor_tag;
        logic [63:0] chunk_key;
        logic [31:0] cost;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic [2:0] op;
    } t_cell_ctl;

endpackage

// File: rtl/cost_bounded_lru_cache_unit.sv
// Top level of the cost-bounded LRU cache: request sequencer around a chain of entry cells.
`timescale 1ns / 1ps
// Requests enter on the slave stream (tuser holds the request type) and results
// leave on the master stream, one transaction per result, with tlast on the final
// result of each request. The byte budget is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while the block is idle, which the block itself does
// not enforce. Entries sit in a chain of cells ordered by recency; the head cell is
// the most recent entry and the valid cells are always contiguous. A request is
// taken only when the sequencer is idle. Each known request type passes through a
// parallel tag compare in S_CMP. Lookup, touch, remove and clear register their
// single result on leaving S_EXEC. A store goes on from S_EXEC through S_FULL, S_INS
// and S_EVICT and stays in S_EVICT for each eviction report caused by the budget;
// a full table is evicted in S_FULL, which every store passes through, adding no
// state. Unknown request types are accepted and dropped. Reset empties the chain,
// zeroes the total and loads the default budget. When the receiver stalls, the
// pending result is held in the output register and the sequencer waits; no further
// requests are accepted until all results of the current one have been registered.
module cost_bounded_lru_cache_unit #(
    parameter int ENTRIES = cblru_pkg::CBL_ENTRIES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // floor_tag, chunk_key, entry_cost, entry_payload, pad
    input  logic [2:0]   i_s_tuser,  // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [143:0] o_m_tdata,  // hit, hit_payload, evicted_floor, evicted_key, total_cost, pad
    output logic [2:0]   o_m_tuser,  // result_kind
    output logic         o_m_tlast
);
    import cblru_pkg::*;

    localparam int TW = (33 + $clog2(ENTRIES) > 38) ? 33 + $clog2(ENTRIES) : 38;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FULL  = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_EVICT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_budget;
    logic [TW-1:0] r_total, n_total;
    logic [CW-1:0] r_count, n_count;
    logic [4:0]    r_nev, n_nev;
    logic [2:0]    r_req;
    logic [3:0]    r_floor;
    logic [63:0]   r_key;
    logic [31:0]   r_cost, r_pay;

    t_cell_ctl w_ctl;
    t_entry    w_head, w_hit, w_tailent, w_new;
    t_entry    w_cell  [ENTRIES];
    t_entry    w_above [ENTRIES];
    t_entry    w_below [ENTRIES];
    logic      w_seen  [ENTRIES+1];
    logic [ENTRIES-1:0] w_match, w_tail;
    logic      w_any, w_accept, w_out_free;

    logic          e_emit, e_hit, e_last;
    logic [2:0]    e_kind;
    logic [31:0]   e_pay;
    logic [3:0]    e_floor;
    logic [63:0]   e_key;
    logic [TW-1:0] e_total;

    logic          r_o_valid, r_o_hit, r_o_last;
    logic [2:0]    r_o_kind;
    logic [31:0]   r_o_pay;
    logic [3:0]    r_o_floor;
    logic [63:0]   r_o_key;
    logic [37:0]   r_o_total;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_out_free = ~r_o_valid | i_m_tready;
    assign w_any      = |w_match;

    assign w_new = '{valid: 1'b1, floor_tag: r_floor, chunk_key: r_key,
                     cost: r_cost, payload: r_pay};
    assign w_head = (w_ctl.op == OP_TOUCH) ? w_hit : w_new;
    assign w_seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_above[g] = w_head;
            end else begin : g_up
                assign w_above[g] = w_cell[g-1];
            end
            if (g == ENTRIES - 1) begin : g_last
                assign w_below[g] = '0;
            end else begin : g_down
                assign w_below[g] = w_cell[g+1];
            end
            cblru_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_tag_floor(r_floor),
                .i_tag_key  (r_key),
                .i_above    (w_above[g]),
                .i_below    (w_below[g]),
                .i_seen     (w_seen[g]),
                .o_seen     (w_seen[g+1]),
                .o_entry    (w_cell[g]),
                .o_match    (w_match[g]),
                .o_tail     (w_tail[g])
            );
        end
    endgenerate

    always_comb begin
        w_hit     = '0;
        w_tailent = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit = w_hit | w_cell[i];
            end
            if (w_tail[i]) begin
                w_tailent = w_tailent | w_cell[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_count = r_count;
        n_nev   = r_nev;
        w_ctl.op = OP_HOLD;
        e_emit  = 1'b0;
        e_kind  = KIND_LOOKUP;
        e_hit   = 1'b0;
        e_pay   = '0;
        e_floor = '0;
        e_key   = '0;
        e_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_tuser <= REQ_CLEAR)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.op = OP_CMP;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                case (r_req)
                    REQ_LOOKUP, REQ_TOUCH: begin
                        if (w_out_free) begin
                            e_emit = 1'b1;
                            e_kind = KIND_LOOKUP;
                            e_hit  = w_any;
                            e_pay  = w_hit.payload;
                            e_last = 1'b1;
                            if (r_req == REQ_TOUCH && w_any) begin
                                w_ctl.op = OP_TOUCH;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (w_out_free) begin
                            if (w_any) begin
                                w_ctl.op = OP_DROP;
                                n_total  = r_total - TW'(w_hit.cost);
                                n_count  = r_count - CW'(1);
                            end
                            e_emit  = 1'b1;
                            e_kind  = KIND_REMOVE;
                            e_hit   = w_any;
                            e_pay   = w_hit.payload;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    REQ_CLEAR: begin
                        if (w_out_free) begin
                            w_ctl.op = OP_CLEAR;
                            n_total  = '0;
                            n_count  = '0;
                            e_emit   = 1'b1;
                            e_kind   = KIND_CLEAR;
                            e_last   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    REQ_STORE: begin
                        if (w_any) begin
                            w_ctl.op = OP_DROP;
                            n_total  = r_total - TW'(w_hit.cost);
                            n_count  = r_count - CW'(1);
                        end
                        n_nev   = '0;
                        n_state = S_FULL;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FULL: begin
                if (r_count == CW'(ENTRIES)) begin
                    if (w_out_free) begin
                        w_ctl.op = OP_KILL;
                        n_total  = r_total - TW'(w_tailent.cost);
                        n_count  = r_count - CW'(1);
                        n_nev    = r_nev + 5'd1;
                        e_emit   = 1'b1;
                        e_kind   = KIND_EVICT;
                        e_floor  = w_tailent.floor_tag;
                        e_key    = w_tailent.chunk_key;
                        n_state  = S_INS;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                w_ctl.op = OP_INSERT;
                n_total  = r_total + TW'(r_cost);
                n_count  = r_count + CW'(1);
                n_state  = S_EVICT;
            end
            S_EVICT: begin
                if (w_out_free) begin
                    e_emit = 1'b1;
                    if ((r_total > TW'(r_budget)) && (r_count > CW'(1))
                        && (r_nev < CBL_MAX_EVICT)) begin
                        w_ctl.op = OP_KILL;
                        n_total  = r_total - TW'(w_tailent.cost);
                        n_count  = r_count - CW'(1);
                        n_nev    = r_nev + 5'd1;
                        e_kind   = KIND_EVICT;
                        e_floor  = w_tailent.floor_tag;
                        e_key    = w_tailent.chunk_key;
                    end else begin
                        e_kind  = KIND_STORE;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        e_total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= CBL_BUDGET_RESET;
            r_total   <= '0;
            r_count   <= '0;
            r_nev     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_count <= n_count;
            r_nev   <= n_nev;
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (e_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_s_tuser;
            r_floor <= i_s_tdata[3:0];
            r_key   <= i_s_tdata[67:4];
            r_cost  <= i_s_tdata[99:68];
            r_pay   <= i_s_tdata[131:100];
        end
        if (e_emit) begin
            r_o_kind  <= e_kind;
            r_o_hit   <= e_hit;
            r_o_pay   <= e_pay;
            r_o_floor <= e_floor;
            r_o_key   <= e_key;
            r_o_last  <= e_last;
            r_o_total <= (e_total > TW'(CBL_TOTAL_MAX)) ? 38'h3F_FFFF_FFFF : e_total[37:0];
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {5'd0, r_o_total, r_o_key, r_o_floor, r_o_pay, r_o_hit};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_match))
        else $error("more than one cell matched the request tag");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tail))
        else $error("valid cells are not contiguous");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count exceeds the number of cells");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("empty cache holds a nonzero total cost");

endmodule

// File: rtl/cblru_cell.sv
// One position of the recency chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module cblru_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cblru_pkg::t_cell_ctl i_ctl,
    input  logic [3:0]         i_tag_floor,
    input  logic [63:0]        i_tag_key,
    input  cblru_pkg::t_entry  i_above,
    input  cblru_pkg::t_entry  i_below,
    input  logic               i_seen,
    output logic               o_seen,
    output cblru_pkg::t_entry  o_entry,
    output logic               o_match,
    output logic               o_tail
);
    import cblru_pkg::*;

    logic   r_valid, n_valid;
    logic   r_match, n_match;
    t_entry r_data, n_data;
    logic   w_load_above, w_load_below;

    assign o_entry = '{valid: r_valid, floor_tag: r_data.floor_tag,
                       chunk_key: r_data.chunk_key, cost: r_data.cost,
                       payload: r_data.payload};
    assign o_match = r_match;
    assign o_seen  = i_seen | r_match;
    assign o_tail  = r_valid & ~i_below.valid;

    always_comb begin
        w_load_above = 1'b0;
        w_load_below = 1'b0;
        n_valid = r_valid;
        n_match = r_match;
        n_data  = r_data;
        case (i_ctl.op)
            OP_CMP: begin
                n_match = r_valid && (r_data.floor_tag == i_tag_floor)
                          && (r_data.chunk_key == i_tag_key);
            end
            OP_TOUCH:  w_load_above = ~i_seen;
            OP_DROP:   w_load_below = i_seen | r_match;
            OP_INSERT: w_load_above = 1'b1;
            OP_KILL: begin
                if (o_tail) begin
                    n_valid = 1'b0;
                end
            end
            OP_CLEAR:  n_valid = 1'b0;
            default: ;
        endcase
        if (w_load_above) begin
            n_valid = i_above.valid;
            n_data  = i_above;
        end else if (w_load_below) begin
            n_valid = i_below.valid;
            n_data  = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// File: verif/tb_cost_bounded_lru_cache_unit.sv
// Self-checking testbench of the cost-bounded LRU cache with a transaction scoreboard.
`timescale 1ns / 1ps
module tb_cost_bounded_lru_cache_unit;
    import cblru_pkg::*;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam int NSLOT = CBL_ENTRIES;
    localparam int IDLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]  kind;
        logic        hit;
        logic [31:0] payload;
        logic [3:0]  ev_floor;
        logic [63:0] ev_key;
        logic [37:0] total;
        logic        last;
    } t_cache_result;

    class t_cache_scoreboard;
        logic        slot_used[NSLOT];
        logic [3:0]  slot_floor[NSLOT];
        logic [63:0] slot_key[NSLOT];
        logic [31:0] slot_cost[NSLOT];
        logic [31:0] slot_payload[NSLOT];
        int          slot_rank[NSLOT];
        logic [63:0] cost_sum;
        int          used_count;
        logic [31:0] budget;
        t_cache_result awaited[$];
        int          errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            cost_sum = '0;
            used_count = 0;
            budget = CBL_BUDGET_RESET;
            errors = 0;
        endfunction

        function void add_result(logic [2:0] kind, logic hit, logic [31:0] pay,
                                 logic [3:0] fl, logic [63:0] key);
            t_cache_result r;
            r.kind = kind;
            r.hit = hit;
            r.payload = pay;
            r.ev_floor = fl;
            r.ev_key = key;
            r.total = (cost_sum > CBL_TOTAL_MAX) ? CBL_TOTAL_MAX[37:0] : cost_sum[37:0];
            r.last = 1'b0;
            awaited.insert(awaited.size(), r);
        endfunction

        function int find_tag(logic [3:0] fl, logic [63:0] key);
            for (int i = 0; i < NSLOT; i++)
                if (slot_used[i] && slot_floor[i] == fl && slot_key[i] == key) return i;
            return -1;
        endfunction

        function void drop_entry(int s);
            int r;
            r = slot_rank[s];
            cost_sum -= slot_cost[s];
            slot_used[s] = 1'b0;
            used_count--;
            for (int j = 0; j < NSLOT; j++)
                if (slot_used[j] && slot_rank[j] > r) slot_rank[j]--;
        endfunction

        function void evict_oldest();
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_used[i] && slot_rank[i] == used_count - 1) begin
                    drop_entry(i);
                    add_result(KIND_EVICT, 1'b0, '0, slot_floor[i], slot_key[i]);
                    return;
                end
            end
        endfunction

        function void note_request(logic [2:0] req, logic [3:0] fl, logic [63:0] key,
                                   logic [31:0] cost, logic [31:0] pay);
            int s;
            int made;
            int start;
            start = awaited.size();
            if (req == REQ_LOOKUP || req == REQ_TOUCH) begin
                s = find_tag(fl, key);
                if (s >= 0) begin
                    if (req == REQ_TOUCH) begin
                        for (int j = 0; j < NSLOT; j++)
                            if (slot_used[j] && slot_rank[j] < slot_rank[s]) slot_rank[j]++;
                        slot_rank[s] = 0;
                    end
                    add_result(KIND_LOOKUP, 1'b1, slot_payload[s], '0, '0);
                end else begin
                    add_result(KIND_LOOKUP, 1'b0, '0, '0, '0);
                end
            end else if (req == REQ_STORE) begin
                s = find_tag(fl, key);
                if (s >= 0) drop_entry(s);
                if (used_count >= NSLOT) evict_oldest();
                s = -1;
                for (int j = 0; j < NSLOT; j++)
                    if (!slot_used[j] && s < 0) s = j;
                if (s >= 0) begin
                    for (int j = 0; j < NSLOT; j++)
                        if (slot_used[j]) slot_rank[j]++;
                    slot_used[s] = 1'b1;
                    slot_floor[s] = fl;
                    slot_key[s] = key;
                    slot_cost[s] = cost;
                    slot_payload[s] = pay;
                    slot_rank[s] = 0;
                    used_count++;
                    cost_sum += cost;
                end
                made = awaited.size() - start;
                while (cost_sum > {32'd0, budget} && used_count > 1 && made < CBL_MAX_EVICT) begin
                    evict_oldest();
                    made++;
                end
                add_result(KIND_STORE, 1'b0, '0, '0, '0);
            end else if (req == REQ_REMOVE) begin
                s = find_tag(fl, key);
                if (s >= 0) begin
                    drop_entry(s);
                    add_result(KIND_REMOVE, 1'b1, slot_payload[s], '0, '0);
                end else begin
                    add_result(KIND_REMOVE, 1'b0, '0, '0, '0);
                end
            end else if (req == REQ_CLEAR) begin
                for (int j = 0; j < NSLOT; j++) begin
                    slot_used[j] = 1'b0;
                    slot_rank[j] = 0;
                end
                cost_sum = '0;
                used_count = 0;
                add_result(KIND_CLEAR, 1'b0, '0, '0, '0);
            end
            if (awaited.size() > start) awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_cache_result got);
            t_cache_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual kind %h",
                         $time, got.kind);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            compare_field("result_kind", want.kind, got.kind);
            compare_field("hit", want.hit, got.hit);
            compare_field("hit_payload", want.payload, got.payload);
            compare_field("evicted_floor", want.ev_floor, got.ev_floor);
            compare_field("evicted_key", want.ev_key, got.ev_key);
            compare_field("total_cost", want.total, got.total);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;  // floor_tag, chunk_key, entry_cost, entry_payload, pad
    logic [2:0]   i_s_tuser = '0;  // req_type
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [143:0] o_m_tdata;  // hit, hit_payload, evicted_floor, evicted_key, total_cost, pad
    logic [2:0]   o_m_tuser;  // result_kind
    logic         o_m_tlast;

    t_cache_scoreboard sb = new();
    bit          gaps_on = 1'b1;
    int          stall_left = 0;
    int          cycles = 0;
    logic [3:0]  pool_floor[12];
    logic [63:0] pool_key[12];

    cost_bounded_lru_cache_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cache_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tuser;
            got.hit = o_m_tdata[0];
            got.payload = o_m_tdata[32:1];
            got.ev_floor = o_m_tdata[36:33];
            got.ev_key = o_m_tdata[100:37];
            got.total = o_m_tdata[138:101];
            got.last = o_m_tlast;
            sb.check_result(got);
            stall_left <= gaps_on ? $urandom_range(0, 4) : 0;
        end
    end

    task automatic send_request(logic [2:0] req, logic [3:0] fl, logic [63:0] key,
                                logic [31:0] cost, logic [31:0] pay);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= req;
        i_s_tdata <= {4'd0, pay, cost, key, fl};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req, fl, key, cost, pay);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_budget(logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.budget = value;
        @(negedge i_clk);
    endtask

    task automatic random_request(logic [31:0] cost_hi);
        int pick;
        int p;
        logic [2:0] req;
        logic [3:0] fl;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        p = $urandom_range(0, 11);
        if (pick < 40) req = REQ_STORE;
        else if (pick < 60) req = REQ_LOOKUP;
        else if (pick < 78) req = REQ_TOUCH;
        else if (pick < 94) req = REQ_REMOVE;
        else if (pick < 97) req = REQ_CLEAR;
        else req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        fl = pool_floor[p];
        key = pool_key[p];
        if ($urandom_range(0, 9) == 0) begin
            fl = 4'($urandom);
            key = {$urandom, $urandom};
        end
        send_request(req, fl, key, $urandom_range(0, cost_hi), $urandom);
    endtask

    initial begin
        logic [31:0] phase_budget[5];
        logic [31:0] phase_cost[5];
        for (int i = 0; i < 12; i++) begin
            pool_floor[i] = 4'($urandom);
            pool_key[i] = {$urandom, $urandom};
        end
        pool_floor[0] = '0;
        pool_key[0] = '0;
        pool_floor[1] = '1;
        pool_key[1] = '1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: extremes, every request type, misses and unused codes.
        send_request(REQ_LOOKUP, '0, '0, '0, '0);
        send_request(REQ_REMOVE, '1, '1, '0, '0);
        send_request(REQ_STORE, '0, '0, '0, '1);
        send_request(REQ_STORE, '1, '1, 32'd1000, 32'h5a5a_a5a5);
        send_request(REQ_STORE, '0, '0, 32'd7, 32'h1234_5678);
        send_request(REQ_TOUCH, '1, '1, '0, '0);
        send_request(REQ_LOOKUP, '0, '0, '0, '0);
        send_request(REQ_UNUSED_LO, '0, '0, '1, '1);
        send_request(3'(REQ_UNUSED_LO + 3'd1), '1, '1, '1, '1);
        send_request(REQ_UNUSED_HI, '0, '0, '0, '0);
        send_request(REQ_STORE, 4'd3, 64'h8000_0000_0000_0001, '1, '1);
        send_request(REQ_REMOVE, '1, '1, '0, '0);
        send_request(REQ_REMOVE, '1, '1, '0, '0);
        send_request(REQ_CLEAR, '0, '0, '0, '0);
        send_request(REQ_LOOKUP, '0, '0, '0, '0);
        wait_drained();

        // Fill the table under the largest budget, then store past full and
        // drop the budget to zero to reach the cap on evictions per store.
        write_budget('1);
        gaps_on = 1'b0;
        for (int i = 0; i < NSLOT + 1; i++)
            send_request(REQ_STORE, 4'(i), {$urandom, $urandom}, 32'd1000, 32'(i));
        wait_drained();
        write_budget('0);
        send_request(REQ_STORE, 4'd9, 64'd99, 32'd5, 32'd5);
        send_request(REQ_STORE, 4'd9, 64'd98, 32'd0, 32'd6);
        send_request(REQ_CLEAR, '0, '0, '0, '0);
        gaps_on = 1'b1;
        wait_drained();

        phase_budget[0] = CBL_BUDGET_RESET;
        phase_cost[0] = '1;
        phase_budget[1] = 32'd2000;
        phase_cost[1] = 32'd500;
        phase_budget[2] = '1;
        phase_cost[2] = '1;
        phase_budget[3] = 32'd0;
        phase_cost[3] = 32'd3;
        phase_budget[4] = $urandom_range(3000, 20000);
        phase_cost[4] = 32'd1500;
        for (int ph = 0; ph < 5; ph++) begin
            write_budget(phase_budget[ph]);
            gaps_on = (ph != 2);
            repeat (80) random_request(phase_cost[ph]);
            wait_drained();
        end

        repeat (IDLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
